### rtl/sfcc_pkg.sv
// Shared types, constants and the CRC-16/ARC byte update for the framed link codec.
`default_nettype none

package sfcc_pkg;

	// Request and result payloads
	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic       frame_end;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_kind;
		logic [2:0] rx_status;
		logic       run_last;
	} res_t;

	// Up to three results caused by one request, first result in entry 0
	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		logic [1:0]               cnt;
		res_t [MAX_RES-1:0]       r;
	} res_set_t;

	// Request kinds and result kinds
	localparam logic REQ_SEND = 1'b0;
	localparam logic REQ_RECV = 1'b1;
	localparam logic KIND_TX  = 1'b0;
	localparam logic KIND_RX  = 1'b1;

	// Receive status codes
	localparam logic [2:0] RX_PENDING   = 3'd0;
	localparam logic [2:0] RX_ACK       = 3'd1;
	localparam logic [2:0] RX_BAD_START = 3'd2;
	localparam logic [2:0] RX_BAD_OP    = 3'd3;
	localparam logic [2:0] RX_BAD_CRC   = 3'd4;

	// Configuration register map
	localparam int unsigned CFG_IDX_W    = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE   = 8'd1;
	localparam logic [7:0] START_BYTE_RST = 8'hAA;
	localparam logic [7:0] ACK_CODE_RST   = 8'h03;

	// Reflected form of polynomial 0x8005
	localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

	// Fold one byte into a CRC-16/ARC value, least significant bit first
	function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc_in,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/sfcc_tx.sv
// Transmit framer: pass bytes through, keep the running CRC, append it on frame end.
`default_nettype none

module sfcc_tx (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire logic [7:0]          data_byte,
	input  wire logic                frame_end,
	output sfcc_pkg::res_set_t       set
);

	logic [15:0] tx_crc_q;
	logic [15:0] crc_nxt;

	assign crc_nxt = sfcc_pkg::crc16_arc_byte(tx_crc_q, data_byte);

	// Build the byte, then CRC high and low bytes when the frame closes
	always_comb begin
		set = '0;
		set.r[0].out_byte = data_byte;
		set.r[0].out_kind = sfcc_pkg::KIND_TX;
		set.r[1].out_byte = crc_nxt[15:8];
		set.r[1].out_kind = sfcc_pkg::KIND_TX;
		set.r[2].out_byte = crc_nxt[7:0];
		set.r[2].out_kind = sfcc_pkg::KIND_TX;
		set.r[2].run_last = 1'b1;
		if (frame_end) begin
			set.cnt = 2'd3;
		end else begin
			set.cnt = 2'd1;
			set.r[0].run_last = 1'b1;
		end
	end

	// Advance the CRC, clear it after the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_crc_q <= '0;
		end else if (fire) begin
			tx_crc_q <= frame_end ? 16'h0000 : crc_nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/sfcc_rx.sv
// Receive parser: check start, acknowledge opcode and big-endian CRC of a frame.
`default_nettype none

module sfcc_rx (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  start_byte,
	input  wire logic [7:0]  ack_code,
	output logic [2:0]       status
);

	typedef enum logic [1:0] {
		WAIT_START = 2'd0,
		WAIT_OP    = 2'd1,
		WAIT_HI    = 2'd2,
		WAIT_LO    = 2'd3
	} phase_t;

	phase_t      phase_q, phase_nxt;
	logic [15:0] rx_crc_q, crc_nxt;
	logic [7:0]  crc_hi_q;

	// Decide status and next parser state for this byte
	always_comb begin
		phase_nxt = phase_q;
		crc_nxt   = rx_crc_q;
		status    = sfcc_pkg::RX_PENDING;
		case (phase_q)
			WAIT_START: begin
				if (data_byte == start_byte) begin
					crc_nxt   = sfcc_pkg::crc16_arc_byte(16'h0000, data_byte);
					phase_nxt = WAIT_OP;
				end else begin
					status  = sfcc_pkg::RX_BAD_START;
					crc_nxt = '0;
				end
			end
			WAIT_OP: begin
				if (data_byte == ack_code) begin
					crc_nxt   = sfcc_pkg::crc16_arc_byte(rx_crc_q, data_byte);
					phase_nxt = WAIT_HI;
				end else begin
					status    = sfcc_pkg::RX_BAD_OP;
					crc_nxt   = '0;
					phase_nxt = WAIT_START;
				end
			end
			WAIT_HI: begin
				phase_nxt = WAIT_LO;
			end
			WAIT_LO: begin
				status    = ({crc_hi_q, data_byte} == rx_crc_q) ?
					sfcc_pkg::RX_ACK : sfcc_pkg::RX_BAD_CRC;
				crc_nxt   = '0;
				phase_nxt = WAIT_START;
			end
			default: begin
				crc_nxt   = '0;
				phase_nxt = WAIT_START;
			end
		endcase
	end

	// Hold parser state between received bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= WAIT_START;
			rx_crc_q <= '0;
			crc_hi_q <= '0;
		end else if (fire) begin
			phase_q  <= phase_nxt;
			rx_crc_q <= crc_nxt;
			if (phase_q == WAIT_HI) begin
				crc_hi_q <= data_byte;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/sfcc_resq.sv
// Result register: holds up to three results of one request and drains them in order.
`default_nettype none

module sfcc_resq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire sfcc_pkg::res_set_t   set,
	output logic                      free,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output sfcc_pkg::res_t            res
);

	sfcc_pkg::res_t [sfcc_pkg::MAX_RES-1:0] res_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign res_valid = (cnt_q != 2'd0);
	assign res       = res_q[0];
	assign pop       = res_valid && !res_stall;
	// Room for a new request once the last waiting result leaves
	assign free      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

	// Track how many results wait
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= set.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Load a new set or advance the line of waiting results
	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= set.r;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

`default_nettype wire

### rtl/serial_frame_crc_codec.sv
// Framed link codec top level: CRC-16/ARC transmit framer and acknowledge parser.
// The first result of a request is registered and valid in the cycle after it is accepted.
// Throughput: one request per cycle while results are taken; a send request with
// frame_end yields three results and stalls requests until the last one is taken.
// Reset clears both CRCs and the parser and loads start_byte 0xAA, ack_code 0x03.
// Configuration writes are always ready and take effect on the next request.
`default_nettype none

module serial_frame_crc_codec (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire sfcc_pkg::req_t                 req,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output sfcc_pkg::res_t                      res,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [sfcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                     cfg_data
);

	logic               free, push, tx_fire, rx_fire;
	logic [7:0]         start_byte_q, ack_code_q;
	logic [2:0]         rx_status;
	sfcc_pkg::res_set_t tx_set, set;

	assign cfg_ready = 1'b1;
	assign req_stall = !free;
	assign push      = req_valid && free;
	assign tx_fire   = push && (req.req_type == sfcc_pkg::REQ_SEND);
	assign rx_fire   = push && (req.req_type == sfcc_pkg::REQ_RECV);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= sfcc_pkg::START_BYTE_RST;
			ack_code_q   <= sfcc_pkg::ACK_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == sfcc_pkg::CFG_START_BYTE) begin
				start_byte_q <= cfg_data;
			end
			if (cfg_index == sfcc_pkg::CFG_ACK_CODE) begin
				ack_code_q <= cfg_data;
			end
		end
	end

	sfcc_tx u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (tx_fire),
		.data_byte (req.data_byte),
		.frame_end (req.frame_end),
		.set       (tx_set)
	);

	sfcc_rx u_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (rx_fire),
		.data_byte  (req.data_byte),
		.start_byte (start_byte_q),
		.ack_code   (ack_code_q),
		.status     (rx_status)
	);

	// Select the result set of the request direction
	always_comb begin
		if (req.req_type == sfcc_pkg::REQ_SEND) begin
			set = tx_set;
		end else begin
			set = '0;
			set.cnt = 2'd1;
			set.r[0].out_kind  = sfcc_pkg::KIND_RX;
			set.r[0].rx_status = rx_status;
			set.r[0].run_last  = 1'b1;
		end
	end

	sfcc_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.set       (set),
		.free      (free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire

### tb/tb_serial_frame_crc_codec.sv
// Self-checking testbench for the framed link codec: CRC framer and acknowledge parser.
`timescale 1ns / 100ps

module tb_serial_frame_crc_codec;

	localparam logic [15:0] CRC16_POLY = 16'h8005;
	localparam int unsigned STUCK_LIMIT = 1000;
	localparam int unsigned MAX_REPORTS = 10;
	// Indexes outside the register map; writes there must change nothing
	localparam logic [sfcc_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd2;
	localparam logic [sfcc_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP    = 8'hFF;

	typedef enum logic [1:0] {
		RX_WAIT_START,
		RX_WAIT_OP,
		RX_WAIT_CRC_HI,
		RX_WAIT_CRC_LO
	} rx_step_t;

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           req_valid = 1'b0;
	logic                           req_stall;
	sfcc_pkg::req_t                 req = '0;
	logic                           res_valid;
	logic                           res_stall = 1'b0;
	sfcc_pkg::res_t                 res;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [sfcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                     cfg_data = '0;

	// Mirror of the codec state and registers
	logic [15:0] tx_acc;
	logic [15:0] rx_acc;
	rx_step_t    rx_step;
	logic [7:0]  rx_hi;
	logic [7:0]  start_cfg;
	logic [7:0]  ack_cfg;

	sfcc_pkg::res_t link_out_q[$];
	int unsigned    fault_cnt = 0;
	int unsigned    items_sent = 0;
	int unsigned    burst_left = 0;
	int unsigned    stuck_cnt = 0;
	int unsigned    stall_run = 0;
	int unsigned    stall_mode = 0;

	serial_frame_crc_codec u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Shift one byte into the augmented CRC register, lsb first
	function automatic logic [15:0] crc_aug_shift(input logic [15:0] acc,
		input logic [7:0] b);
		logic msb;
		for (int k = 0; k < 8; k++) begin
			msb = acc[15];
			acc = {acc[14:0], b[k]};
			if (msb) begin
				acc = acc ^ CRC16_POLY;
			end
		end
		return acc;
	endfunction

	// Flush two zero bytes and bit-reverse to get the CRC-16/ARC value
	function automatic logic [15:0] crc_aug_finish(input logic [15:0] acc);
		logic [15:0] rev;
		acc = crc_aug_shift(crc_aug_shift(acc, 8'h00), 8'h00);
		for (int k = 0; k < 16; k++) begin
			rev[k] = acc[15 - k];
		end
		return rev;
	endfunction

	function automatic logic [15:0] ack_frame_crc(input logic [7:0] s,
		input logic [7:0] op);
		return crc_aug_finish(crc_aug_shift(crc_aug_shift(16'h0000, s), op));
	endfunction

	function automatic void push_link_out(input logic [7:0] b, input logic kind,
		input logic [2:0] status, input logic last);
		sfcc_pkg::res_t o;
		o.out_byte  = b;
		o.out_kind  = kind;
		o.rx_status = status;
		o.run_last  = last;
		link_out_q.push_back(o);
	endfunction

	// Advance the mirrored codec by one request and queue its results
	function automatic void advance_codec(input sfcc_pkg::req_t r);
		logic [2:0]  status;
		logic [15:0] c;
		status = sfcc_pkg::RX_PENDING;
		if (r.req_type == sfcc_pkg::REQ_SEND) begin
			tx_acc = crc_aug_shift(tx_acc, r.data_byte);
			if (!r.frame_end) begin
				push_link_out(r.data_byte, sfcc_pkg::KIND_TX, sfcc_pkg::RX_PENDING, 1'b1);
			end else begin
				c = crc_aug_finish(tx_acc);
				push_link_out(r.data_byte, sfcc_pkg::KIND_TX, sfcc_pkg::RX_PENDING, 1'b0);
				push_link_out(c[15:8], sfcc_pkg::KIND_TX, sfcc_pkg::RX_PENDING, 1'b0);
				push_link_out(c[7:0], sfcc_pkg::KIND_TX, sfcc_pkg::RX_PENDING, 1'b1);
				tx_acc = 16'h0000;
			end
		end else begin
			case (rx_step)
				RX_WAIT_START: begin
					if (r.data_byte == start_cfg) begin
						rx_acc  = crc_aug_shift(16'h0000, r.data_byte);
						rx_step = RX_WAIT_OP;
					end else begin
						status = sfcc_pkg::RX_BAD_START;
						rx_acc = 16'h0000;
					end
				end
				RX_WAIT_OP: begin
					if (r.data_byte == ack_cfg) begin
						rx_acc  = crc_aug_shift(rx_acc, r.data_byte);
						rx_step = RX_WAIT_CRC_HI;
					end else begin
						status  = sfcc_pkg::RX_BAD_OP;
						rx_acc  = 16'h0000;
						rx_step = RX_WAIT_START;
					end
				end
				RX_WAIT_CRC_HI: begin
					rx_hi   = r.data_byte;
					rx_step = RX_WAIT_CRC_LO;
				end
				default: begin
					status  = ({rx_hi, r.data_byte} == crc_aug_finish(rx_acc)) ?
						sfcc_pkg::RX_ACK : sfcc_pkg::RX_BAD_CRC;
					rx_acc  = 16'h0000;
					rx_step = RX_WAIT_START;
				end
			endcase
			push_link_out(8'h00, sfcc_pkg::KIND_RX, status, 1'b1);
		end
	endfunction

	// Send one request, idling between bursts, and hold it until accepted
	task automatic send_req(input logic kind, input logic [7:0] b, input logic fe);
		sfcc_pkg::req_t r;
		int unsigned    gap;
		r.req_type  = kind;
		r.data_byte = b;
		r.frame_end = fe;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		advance_codec(r);
		items_sent++;
	endtask

	// Write one register, then drop valid before returning
	task automatic write_cfg(input logic [sfcc_pkg::CFG_IDX_W-1:0] idx,
		input logic [7:0] d);
		cfg_index <= idx;
		cfg_data  <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == sfcc_pkg::CFG_START_BYTE) begin
			start_cfg = d;
		end else if (idx == sfcc_pkg::CFG_ACK_CODE) begin
			ack_cfg = d;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending and wait until every queued result has come out
	task automatic drain_results();
		req_valid  <= 1'b0;
		burst_left = 0;
		while (link_out_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_tx_framing();
		send_req(sfcc_pkg::REQ_SEND, 8'h00, 1'b0);
		send_req(sfcc_pkg::REQ_SEND, 8'hFF, 1'b1);
		// single-byte frame
		send_req(sfcc_pkg::REQ_SEND, 8'h80, 1'b1);
		send_req(sfcc_pkg::REQ_SEND, 8'h01, 1'b0);
		send_req(sfcc_pkg::REQ_SEND, 8'hFE, 1'b0);
		send_req(sfcc_pkg::REQ_SEND, 8'h5A, 1'b1);
	endtask

	task automatic test_rx_parser();
		logic [15:0] c;
		c = ack_frame_crc(start_cfg, ack_cfg);
		// good acknowledge frame
		send_req(sfcc_pkg::REQ_RECV, start_cfg, 1'b0);
		send_req(sfcc_pkg::REQ_RECV, ack_cfg, 1'b0);
		send_req(sfcc_pkg::REQ_RECV, c[15:8], 1'b0);
		send_req(sfcc_pkg::REQ_RECV, c[7:0], 1'b0);
		// bad start, then bad op
		send_req(sfcc_pkg::REQ_RECV, ~start_cfg, 1'b0);
		send_req(sfcc_pkg::REQ_RECV, start_cfg, 1'b0);
		send_req(sfcc_pkg::REQ_RECV, ack_cfg ^ 8'h07, 1'b0);
		// start byte in the op slot is consumed, not taken as a new start
		send_req(sfcc_pkg::REQ_RECV, start_cfg, 1'b0);
		send_req(sfcc_pkg::REQ_RECV, start_cfg, 1'b0);
		// good frame with a send byte in the middle and frame_end set on receive
		send_req(sfcc_pkg::REQ_RECV, start_cfg, 1'b1);
		send_req(sfcc_pkg::REQ_RECV, ack_cfg, 1'b1);
		send_req(sfcc_pkg::REQ_SEND, 8'h3C, 1'b1);
		send_req(sfcc_pkg::REQ_RECV, c[15:8], 1'b1);
		send_req(sfcc_pkg::REQ_RECV, c[7:0], 1'b1);
		// bad CRC
		send_req(sfcc_pkg::REQ_RECV, start_cfg, 1'b0);
		send_req(sfcc_pkg::REQ_RECV, ack_cfg, 1'b0);
		send_req(sfcc_pkg::REQ_RECV, c[15:8], 1'b0);
		send_req(sfcc_pkg::REQ_RECV, c[7:0] ^ 8'h80, 1'b0);
	endtask

	// Mostly well-formed frames in both directions, plus noise and broken frames
	task automatic test_random_traffic(input int unsigned n);
		int unsigned first;
		int unsigned len;
		int unsigned flavor;
		logic [15:0] c;
		logic [7:0]  op;
		first = items_sent;
		while (items_sent - first < n) begin
			flavor = $urandom_range(0, 99);
			if (flavor < 35) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					send_req(sfcc_pkg::REQ_SEND, 8'($urandom_range(0, 255)), i == len - 1);
				end
			end else if (flavor < 85) begin
				c  = ack_frame_crc(start_cfg, ack_cfg);
				op = ack_cfg;
				len = $urandom_range(0, 9);
				if (len == 0) begin
					c[15:8] = c[15:8] ^ (8'h01 << $urandom_range(0, 7));
				end else if (len == 1) begin
					c[7:0] = c[7:0] ^ (8'h01 << $urandom_range(0, 7));
				end else if (len == 2) begin
					op = ack_cfg ^ 8'($urandom_range(1, 255));
				end
				send_req(sfcc_pkg::REQ_RECV, start_cfg, 1'($urandom_range(0, 1)));
				send_req(sfcc_pkg::REQ_RECV, op, 1'($urandom_range(0, 1)));
				if (op == ack_cfg) begin
					send_req(sfcc_pkg::REQ_RECV, c[15:8], 1'($urandom_range(0, 1)));
					send_req(sfcc_pkg::REQ_RECV, c[7:0], 1'($urandom_range(0, 1)));
				end
			end else if (flavor < 93) begin
				send_req(sfcc_pkg::REQ_RECV, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else begin
				// truncated frame: a lone start byte
				send_req(sfcc_pkg::REQ_RECV, start_cfg, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic test_cfg_sweep();
		write_cfg(CFG_IDX_UNUSED, 8'h00);
		write_cfg(CFG_IDX_TOP, 8'h00);
		test_random_traffic(30);
		drain_results();
		write_cfg(sfcc_pkg::CFG_START_BYTE, 8'h00);
		write_cfg(sfcc_pkg::CFG_ACK_CODE, 8'hFF);
		test_random_traffic(30);
		drain_results();
		write_cfg(sfcc_pkg::CFG_START_BYTE, 8'hFF);
		write_cfg(sfcc_pkg::CFG_ACK_CODE, 8'h00);
		test_random_traffic(30);
		drain_results();
		// start and ack codes equal
		write_cfg(sfcc_pkg::CFG_START_BYTE, 8'h5A);
		write_cfg(sfcc_pkg::CFG_ACK_CODE, 8'h5A);
		test_random_traffic(20);
		drain_results();
		write_cfg(sfcc_pkg::CFG_START_BYTE, 8'($urandom_range(0, 255)));
		write_cfg(sfcc_pkg::CFG_ACK_CODE, 8'($urandom_range(0, 255)));
		test_random_traffic(25);
		drain_results();
	endtask

	// Sequence the tests after reset
	initial begin
		tx_acc    = 16'h0000;
		rx_acc    = 16'h0000;
		rx_step   = RX_WAIT_START;
		rx_hi     = 8'h00;
		start_cfg = sfcc_pkg::START_BYTE_RST;
		ack_cfg   = sfcc_pkg::ACK_CODE_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_tx_framing();
		test_rx_parser();
		drain_results();
		test_random_traffic(30);
		drain_results();
		test_cfg_sweep();
		if (link_out_q.size() != 0) begin
			fault_cnt++;
		end
		if (fault_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Drive result stall from a randomly chosen pattern that changes when its run ends
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_run  <= $urandom_range(20, 80);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_mode)
			0: begin
				res_stall <= 1'b0;
			end
			1: begin
				res_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				res_stall <= (stall_run % 4 == 0);
			end
			default: begin
				res_stall <= ($urandom_range(0, 1) == 1);
			end
		endcase
	end

	// Compare each accepted result with the oldest queued one
	always @(posedge clk) begin
		sfcc_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (link_out_q.size() == 0) begin
				if (fault_cnt < MAX_REPORTS) begin
					$display("%0t: result with none pending: byte %h kind %0d %s",
						$time, res.out_byte, res.out_kind,
						$sformatf("status %0d last %0d", res.rx_status, res.run_last));
				end
				fault_cnt++;
			end else begin
				want = link_out_q.pop_front();
				if (res.out_byte !== want.out_byte || res.out_kind !== want.out_kind ||
					res.rx_status !== want.rx_status ||
					res.run_last !== want.run_last) begin
					if (fault_cnt < MAX_REPORTS) begin
						$display("%0t: mismatch want/got byte %h/%h kind %0d/%0d %s",
							$time, want.out_byte, res.out_byte,
							want.out_kind, res.out_kind,
							$sformatf("status %0d/%0d last %0d/%0d",
								want.rx_status, res.rx_status,
								want.run_last, res.run_last));
					end
					fault_cnt++;
				end
			end
		end
	end

	// End the run when no channel moves for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall) ||
			(cfg_valid && cfg_ready)) begin
			stuck_cnt <= 0;
		end else begin
			stuck_cnt <= stuck_cnt + 1;
		end
		if (stuck_cnt >= STUCK_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

### filelist.f
rtl/sfcc_pkg.sv
rtl/sfcc_tx.sv
rtl/sfcc_rx.sv
rtl/sfcc_resq.sv
rtl/serial_frame_crc_codec.sv
tb/tb_serial_frame_crc_codec.sv
